// ===== rtl/core/video_gate_array_interrupt_blanking_top_assert.svh =====
// Assertion macros for the video gate array interrupt and blanking block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef VIDEO_GATE_ARRAY_INTERRUPT_BLANKING_TOP_ASSERT_SVH
`define VIDEO_GATE_ARRAY_INTERRUPT_BLANKING_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define VGAIB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define VGAIB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vgaib_pkg.sv =====
// ----------------------------------------------------------------------------
// vgaib_pkg
// Event codes, write function codes and timing constants for the video
// gate array interrupt and blanking block.
// ----------------------------------------------------------------------------
package vgaib_pkg;

    typedef enum logic [2:0] {
        CMD_HSYNC  = 3'd0,
        CMD_VSYNC  = 3'd1,
        CMD_DISPEN = 3'd2,
        CMD_TICK   = 3'd3,
        CMD_WRITE  = 3'd4,
        CMD_ACK    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        WFN_PEN    = 2'd0,
        WFN_COLOUR = 2'd1,
        WFN_CONFIG = 2'd2,
        WFN_NONE   = 2'd3
    } wfn_t;

    localparam int PEN_COUNT = 17;
    localparam int PEN_W     = $clog2(PEN_COUNT);

    localparam logic [5:0]       IRQ_LINES     = 6'd52;
    localparam logic [5:0]       RESYNC_LIMIT  = 6'd32;
    localparam logic [4:0]       VBLANK_LEN    = 5'd26;
    localparam logic [4:0]       VBL_RESYNC    = 5'd2;
    localparam logic [4:0]       VBL_MON_END   = 5'd6;
    localparam logic [2:0]       HBLANK_SAT    = 3'd6;
    localparam logic [2:0]       HBL_MON_START = 3'd1;
    localparam logic [2:0]       HBL_MON_END   = 3'd5;
    localparam logic [PEN_W-1:0] BORDER_PEN    = PEN_W'(16);
    localparam logic [7:0]       CONFIG_RESET  = 8'd128;
    localparam logic [7:0]       ACK_BYTE      = 8'hff;

endpackage

// ===== rtl/core/video_gate_array_interrupt_blanking_top.sv =====
// ----------------------------------------------------------------------------
// video_gate_array_interrupt_blanking_top
// Raster interrupt, blanking, monitor sync and register write handling,
// one event in and one status result out per transfer.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | cmd, level, data
//  output  | out_valid / out_ready| irq_request .. ack_data (twelve fields)
//
//  One event per cycle sustained while out_ready stays high; the input
//  transfer loads the input register, and once the result slot is free
//  the event is applied to the state and loads the result register.
//  Reset clears all timing state; the border pen colour is not kept since no
//  result reads it back.
//  A stalled result holds its register while the input register still takes
//  one more event; both stages hold until the result is taken.
module video_gate_array_interrupt_blanking_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 cmd,
    input  logic                       level,
    input  logic [7:0]                 data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       irq_request,
    output logic                       hblank,
    output logic                       vblank,
    output logic                       border_active,
    output logic                       monitor_hsync,
    output logic                       monitor_vsync,
    output logic [1:0]                 screen_mode,
    output logic [7:0]                 rom_config,
    output logic [vgaib_pkg::PEN_W-1:0] palette_pen,
    output logic [4:0]                 palette_colour,
    output logic                       palette_write,
    output logic [7:0]                 ack_data
);
    import vgaib_pkg::*;

    // input stage
    logic       in_valid_reg;
    logic [2:0] cmd_reg;
    logic       level_reg;
    logic [7:0] data_reg;
    logic       advance;

    // timing state
    logic [5:0]       line_counter_reg, line_counter_next;
    logic             irq_pending_reg, irq_pending_next;
    logic             hsync_in_reg, hsync_in_next;
    logic             vsync_in_reg, vsync_in_next;
    logic             hblank_reg, hblank_next;
    logic             vblank_reg, vblank_next;
    logic             border_reg, border_next;
    logic [2:0]       hblank_cycles_reg, hblank_cycles_next;
    logic [4:0]       vblank_lines_reg, vblank_lines_next;
    logic [PEN_W-1:0] selected_pen_reg, selected_pen_next;
    logic [7:0]       config_reg, config_next;
    logic [1:0]       mode_latch_reg, mode_latch_next;
    logic             mon_hsync_reg, mon_hsync_next;
    logic             mon_vsync_reg, mon_vsync_next;

    // per-event result fields
    logic [PEN_W-1:0] wr_pen;
    logic [4:0]       wr_col;
    logic             wr;
    logic [7:0]       ack;

    // result stage
    logic             out_valid_reg;
    logic             irq_out_reg, hblank_out_reg, vblank_out_reg, border_out_reg;
    logic             mhs_out_reg, mvs_out_reg;
    logic [1:0]       mode_out_reg;
    logic [7:0]       config_out_reg;
    logic [PEN_W-1:0] pen_out_reg;
    logic [4:0]       col_out_reg;
    logic             wr_out_reg;
    logic [7:0]       ack_out_reg;

    // move an event into the result stage when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // hold the accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd;
            level_reg <= level;
            data_reg  <= data;
        end
    end

    // apply one event to the timing state
    always_comb
    begin
        logic [5:0] lc;
        logic [4:0] vl;
        line_counter_next  = line_counter_reg;
        irq_pending_next   = irq_pending_reg;
        hsync_in_next      = hsync_in_reg;
        vsync_in_next      = vsync_in_reg;
        hblank_next        = hblank_reg;
        vblank_next        = vblank_reg;
        border_next        = border_reg;
        hblank_cycles_next = hblank_cycles_reg;
        vblank_lines_next  = vblank_lines_reg;
        selected_pen_next  = selected_pen_reg;
        config_next        = config_reg;
        mode_latch_next    = mode_latch_reg;
        mon_hsync_next     = mon_hsync_reg;
        mon_vsync_next     = mon_vsync_reg;
        wr_pen             = '0;
        wr_col             = '0;
        wr                 = 1'b0;
        ack                = '0;
        lc                 = line_counter_reg + 6'd1;
        vl                 = vblank_lines_reg + 5'd1;

        case (cmd_reg)
            CMD_HSYNC:
            begin
                if (level_reg)
                begin
                    hsync_in_next      = 1'b1;
                    hblank_next        = 1'b1;
                    hblank_cycles_next = '0;
                end
                else
                begin
                    hsync_in_next  = 1'b0;
                    hblank_next    = 1'b0;
                    mon_hsync_next = 1'b0;
                    // count lines; raise the interrupt every 52 lines
                    if (lc == IRQ_LINES)
                    begin
                        lc               = '0;
                        irq_pending_next = 1'b1;
                    end
                    if (vblank_reg)
                    begin
                        vblank_lines_next = vl;
                        if (vl == VBL_RESYNC)
                        begin
                            // resynchronise two lines into vblank
                            if (lc >= RESYNC_LIMIT)
                            begin
                                irq_pending_next = 1'b1;
                            end
                            lc = '0;
                            if (vsync_in_reg)
                            begin
                                mon_vsync_next = 1'b1;
                            end
                        end
                        else if (vl == VBL_MON_END)
                        begin
                            mon_vsync_next = 1'b0;
                        end
                        else if (vl == VBLANK_LEN)
                        begin
                            vblank_next = 1'b0;
                        end
                    end
                    line_counter_next = lc;
                end
            end
            CMD_VSYNC:
            begin
                if (level_reg != vsync_in_reg)
                begin
                    vsync_in_next = level_reg;
                    if (level_reg)
                    begin
                        vblank_next       = 1'b1;
                        vblank_lines_next = '0;
                    end
                    else
                    begin
                        mon_vsync_next = 1'b0;
                    end
                end
            end
            CMD_DISPEN:
            begin
                border_next = !level_reg;
            end
            CMD_TICK:
            begin
                // step through hblank, latch mode and drive monitor hsync
                if (hblank_reg)
                begin
                    if (hblank_cycles_reg == HBL_MON_START)
                    begin
                        mode_latch_next = config_reg[1:0];
                        if (hsync_in_reg)
                        begin
                            mon_hsync_next = 1'b1;
                        end
                    end
                    else if (hblank_cycles_reg == HBL_MON_END)
                    begin
                        mon_hsync_next = 1'b0;
                    end
                    if (hblank_cycles_reg < HBLANK_SAT)
                    begin
                        hblank_cycles_next = hblank_cycles_reg + 3'd1;
                    end
                end
            end
            CMD_WRITE:
            begin
                case (wfn_t'(data_reg[7:6]))
                    WFN_PEN:
                    begin
                        selected_pen_next = data_reg[4] ? BORDER_PEN
                                                        : PEN_W'(data_reg[3:0]);
                    end
                    WFN_COLOUR:
                    begin
                        wr_pen = selected_pen_reg;
                        wr_col = data_reg[4:0];
                        wr     = 1'b1;
                    end
                    WFN_CONFIG:
                    begin
                        config_next = data_reg;
                        if (data_reg[4])
                        begin
                            irq_pending_next  = 1'b0;
                            line_counter_next = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_ACK:
            begin
                line_counter_next = {1'b0, line_counter_reg[4:0]};
                irq_pending_next  = 1'b0;
                ack               = ACK_BYTE;
            end
            default:
            begin
            end
        endcase
    end

    // commit the state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_counter_reg  <= '0;
            irq_pending_reg   <= 1'b0;
            hsync_in_reg      <= 1'b0;
            vsync_in_reg      <= 1'b0;
            hblank_reg        <= 1'b0;
            vblank_reg        <= 1'b0;
            border_reg        <= 1'b0;
            hblank_cycles_reg <= '0;
            vblank_lines_reg  <= '0;
            selected_pen_reg  <= '0;
            config_reg        <= CONFIG_RESET;
            mode_latch_reg    <= '0;
            mon_hsync_reg     <= 1'b0;
            mon_vsync_reg     <= 1'b0;
        end
        else if (advance)
        begin
            line_counter_reg  <= line_counter_next;
            irq_pending_reg   <= irq_pending_next;
            hsync_in_reg      <= hsync_in_next;
            vsync_in_reg      <= vsync_in_next;
            hblank_reg        <= hblank_next;
            vblank_reg        <= vblank_next;
            border_reg        <= border_next;
            hblank_cycles_reg <= hblank_cycles_next;
            vblank_lines_reg  <= vblank_lines_next;
            selected_pen_reg  <= selected_pen_next;
            config_reg        <= config_next;
            mode_latch_reg    <= mode_latch_next;
            mon_hsync_reg     <= mon_hsync_next;
            mon_vsync_reg     <= mon_vsync_next;
        end
    end

    // result valid: set on advance, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // capture the result fields
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            irq_out_reg    <= irq_pending_next;
            hblank_out_reg <= hblank_next;
            vblank_out_reg <= vblank_next;
            border_out_reg <= border_next;
            mhs_out_reg    <= mon_hsync_next;
            mvs_out_reg    <= mon_vsync_next;
            mode_out_reg   <= mode_latch_next;
            config_out_reg <= config_next;
            pen_out_reg    <= wr_pen;
            col_out_reg    <= wr_col;
            wr_out_reg     <= wr;
            ack_out_reg    <= ack;
        end
    end

    assign out_valid      = out_valid_reg;
    assign irq_request    = irq_out_reg;
    assign hblank         = hblank_out_reg;
    assign vblank         = vblank_out_reg;
    assign border_active  = border_out_reg;
    assign monitor_hsync  = mhs_out_reg;
    assign monitor_vsync  = mvs_out_reg;
    assign screen_mode    = mode_out_reg;
    assign rom_config     = config_out_reg;
    assign palette_pen    = pen_out_reg;
    assign palette_colour = col_out_reg;
    assign palette_write  = wr_out_reg;
    assign ack_data       = ack_out_reg;

endmodule

// ===== rtl/core/vgaib_checker.sv =====
// ----------------------------------------------------------------------------
// vgaib_checker
// Port-level checks on the result channel of the interrupt and blanking block.
// ----------------------------------------------------------------------------
`include "video_gate_array_interrupt_blanking_top_assert.svh"

module vgaib_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        hblank,
    input logic                        vblank,
    input logic                        monitor_hsync,
    input logic                        monitor_vsync,
    input logic [vgaib_pkg::PEN_W-1:0] palette_pen,
    input logic [4:0]                  palette_colour,
    input logic                        palette_write,
    input logic [7:0]                  ack_data,
    input logic [7:0]                  rom_config
);
    import vgaib_pkg::*;

    // stalled result holds
    `VGAIB_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(rom_config) && $stable(ack_data), "result changed while stalled")
    // monitor hsync only inside hblank
    `VGAIB_ASSERT_IMP(a_mhs_in_hblank, out_valid && monitor_hsync, hblank,
        "monitor hsync outside hblank")
    // monitor vsync only inside vblank
    `VGAIB_ASSERT_IMP(a_mvs_in_vblank, out_valid && monitor_vsync, vblank,
        "monitor vsync outside vblank")
    // palette fields are zero without a colour write
    `VGAIB_ASSERT_IMP(a_pal_idle, out_valid && !palette_write,
        palette_pen == '0 && palette_colour == '0, "palette fields set without write")
    // acknowledge byte is either zero or the ack value
    `VGAIB_ASSERT_IMP(a_ack_code, out_valid,
        ack_data == '0 || ack_data == ACK_BYTE, "bad acknowledge byte")

endmodule

bind video_gate_array_interrupt_blanking_top vgaib_checker u_vgaib_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hblank         (hblank),
    .vblank         (vblank),
    .monitor_hsync  (monitor_hsync),
    .monitor_vsync  (monitor_vsync),
    .palette_pen    (palette_pen),
    .palette_colour (palette_colour),
    .palette_write  (palette_write),
    .ack_data       (ack_data),
    .rom_config     (rom_config)
);

// ===== dv/gate_status_sb_pkg.sv =====
// ----------------------------------------------------------------------------
// gate_status_sb_pkg
// Status predictor and result store for the video gate array interrupt and
// blanking block: tracks line, vblank, hblank and register state per event
// and checks every result transfer against the oldest predicted status.
// ----------------------------------------------------------------------------
package gate_status_sb_pkg;

    import vgaib_pkg::*;

    typedef struct {
        logic             irq_request;
        logic             hblank;
        logic             vblank;
        logic             border_active;
        logic             monitor_hsync;
        logic             monitor_vsync;
        logic [1:0]       screen_mode;
        logic [7:0]       rom_config;
        logic [PEN_W-1:0] palette_pen;
        logic [4:0]       palette_colour;
        logic             palette_write;
        logic [7:0]       ack_data;
    } gate_status_t;

    class gate_status_scoreboard;

        // timing state
        logic [5:0]       line_count;
        logic             irq_pending;
        logic             hsync_q;
        logic             vsync_q;
        logic             hblank_q;
        logic             vblank_q;
        logic             border_q;
        logic [2:0]       hblank_cycles;
        logic [4:0]       vblank_lines;
        logic             mon_hsync_q;
        logic             mon_vsync_q;

        // register state
        logic [PEN_W-1:0] pen_sel;
        logic [4:0]       pen_colour [PEN_COUNT];
        logic [7:0]       config_q;
        logic [1:0]       mode_q;

        gate_status_t     status_q [$];
        int unsigned      failures;

        function new();
            line_count    = '0;
            irq_pending   = 1'b0;
            hsync_q       = 1'b0;
            vsync_q       = 1'b0;
            hblank_q      = 1'b0;
            vblank_q      = 1'b0;
            border_q      = 1'b0;
            hblank_cycles = '0;
            vblank_lines  = '0;
            mon_hsync_q   = 1'b0;
            mon_vsync_q   = 1'b0;
            pen_sel       = '0;
            foreach (pen_colour[i])
                pen_colour[i] = '0;
            pen_colour[BORDER_PEN] = 5'd20;
            config_q      = CONFIG_RESET;
            mode_q        = '0;
            failures      = 0;
        endfunction

        function int unsigned pending();
            return status_q.size();
        endfunction

        // Advance the state by one accepted event and queue the status it gives.
        function void note_event(logic [2:0] c, logic lvl, logic [7:0] d);
            gate_status_t s;
            s.palette_pen    = '0;
            s.palette_colour = '0;
            s.palette_write  = 1'b0;
            s.ack_data       = '0;
            case (c)
                CMD_HSYNC:
                begin
                    if (lvl)
                    begin
                        hsync_q       = 1'b1;
                        hblank_q      = 1'b1;
                        hblank_cycles = '0;
                    end
                    else
                    begin
                        hsync_q     = 1'b0;
                        hblank_q    = 1'b0;
                        mon_hsync_q = 1'b0;
                        line_count  = line_count + 6'd1;
                        if (line_count == IRQ_LINES)
                        begin
                            line_count  = '0;
                            irq_pending = 1'b1;
                        end
                        if (vblank_q)
                        begin
                            vblank_lines = vblank_lines + 5'd1;
                            if (vblank_lines == VBL_RESYNC)
                            begin
                                // resync: late counter forces the interrupt
                                if (line_count >= RESYNC_LIMIT)
                                    irq_pending = 1'b1;
                                line_count = '0;
                                if (vsync_q)
                                    mon_vsync_q = 1'b1;
                            end
                            else if (vblank_lines == VBL_MON_END)
                                mon_vsync_q = 1'b0;
                            else if (vblank_lines == VBLANK_LEN)
                                vblank_q = 1'b0;
                        end
                    end
                end
                CMD_VSYNC:
                begin
                    // drop a level equal to the current one
                    if (lvl != vsync_q)
                    begin
                        vsync_q = lvl;
                        if (lvl)
                        begin
                            vblank_q     = 1'b1;
                            vblank_lines = '0;
                        end
                        else
                            mon_vsync_q = 1'b0;
                    end
                end
                CMD_DISPEN:
                    border_q = !lvl;
                CMD_TICK:
                begin
                    if (hblank_q)
                    begin
                        if (hblank_cycles == HBL_MON_START)
                        begin
                            mode_q = config_q[1:0];
                            if (hsync_q)
                                mon_hsync_q = 1'b1;
                        end
                        else if (hblank_cycles == HBL_MON_END)
                            mon_hsync_q = 1'b0;
                        if (hblank_cycles < HBLANK_SAT)
                            hblank_cycles = hblank_cycles + 3'd1;
                    end
                end
                CMD_WRITE:
                begin
                    case (wfn_t'(d[7:6]))
                        WFN_PEN:
                            pen_sel = d[4] ? BORDER_PEN : PEN_W'(d[3:0]);
                        WFN_COLOUR:
                        begin
                            pen_colour[pen_sel] = d[4:0];
                            s.palette_pen       = pen_sel;
                            s.palette_colour    = d[4:0];
                            s.palette_write     = 1'b1;
                        end
                        WFN_CONFIG:
                        begin
                            config_q = d;
                            if (d[4])
                            begin
                                irq_pending = 1'b0;
                                line_count  = '0;
                            end
                        end
                        default:
                            ;
                    endcase
                end
                CMD_ACK:
                begin
                    line_count[5] = 1'b0;
                    irq_pending   = 1'b0;
                    s.ack_data    = ACK_BYTE;
                end
                default:
                    ;
            endcase
            s.irq_request   = irq_pending;
            s.hblank        = hblank_q;
            s.vblank        = vblank_q;
            s.border_active = border_q;
            s.monitor_hsync = mon_hsync_q;
            s.monitor_vsync = mon_vsync_q;
            s.screen_mode   = mode_q;
            s.rom_config    = config_q;
            status_q.push_back(s);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void cmp(string name, int unsigned want, int unsigned got);
            if (want != got)
                flag($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        // Compare one result transfer with the oldest predicted status.
        function void check_result(gate_status_t got);
            gate_status_t want;
            if (status_q.size() == 0)
            begin
                flag("result transfer with no status waiting");
                return;
            end
            want = status_q.pop_front();
            cmp("irq_request",    want.irq_request,    got.irq_request);
            cmp("hblank",         want.hblank,         got.hblank);
            cmp("vblank",         want.vblank,         got.vblank);
            cmp("border_active",  want.border_active,  got.border_active);
            cmp("monitor_hsync",  want.monitor_hsync,  got.monitor_hsync);
            cmp("monitor_vsync",  want.monitor_vsync,  got.monitor_vsync);
            cmp("screen_mode",    want.screen_mode,    got.screen_mode);
            cmp("rom_config",     want.rom_config,     got.rom_config);
            cmp("palette_pen",    want.palette_pen,    got.palette_pen);
            cmp("palette_colour", want.palette_colour, got.palette_colour);
            cmp("palette_write",  want.palette_write,  got.palette_write);
            cmp("ack_data",       want.ack_data,       got.ack_data);
        endfunction

    endclass

endpackage

// ===== dv/tb_video_gate_array_interrupt_blanking_top.sv =====
// ----------------------------------------------------------------------------
// tb_video_gate_array_interrupt_blanking_top
// Drives video timing events and register writes into the gate array block,
// first a directed set of corner cases, then random scan lines with vsync
// pulses, writes and acknowledges, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_video_gate_array_interrupt_blanking_top;

    import vgaib_pkg::*;
    import gate_status_sb_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [2:0]           cmd;
    logic                 level;
    logic [7:0]           data;
    logic                 out_valid;
    logic                 out_ready;
    logic                 irq_request;
    logic                 hblank;
    logic                 vblank;
    logic                 border_active;
    logic                 monitor_hsync;
    logic                 monitor_vsync;
    logic [1:0]           screen_mode;
    logic [7:0]           rom_config;
    logic [PEN_W-1:0]     palette_pen;
    logic [4:0]           palette_colour;
    logic                 palette_write;
    logic [7:0]           ack_data;

    gate_status_scoreboard sb;
    gate_status_t          seen;
    bit                    idle_en;
    int unsigned           events_done;
    int unsigned           stall_left;

    always #5 clk = ~clk;

    video_gate_array_interrupt_blanking_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .level          (level),
        .data           (data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .irq_request    (irq_request),
        .hblank         (hblank),
        .vblank         (vblank),
        .border_active  (border_active),
        .monitor_hsync  (monitor_hsync),
        .monitor_vsync  (monitor_vsync),
        .screen_mode    (screen_mode),
        .rom_config     (rom_config),
        .palette_pen    (palette_pen),
        .palette_colour (palette_colour),
        .palette_write  (palette_write),
        .ack_data       (ack_data)
    );

    // Present one event, optionally after an idle burst, and hold it until
    // the transfer happens.
    task automatic send_event(input logic [2:0] c, input logic l, input logic [7:0] d);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        level    <= l;
        data     <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_event(c, l, d);
        if (c <= CMD_ACK)
            events_done++;
    endtask

    // Mostly well-formed register bytes, with config clears kept rare.
    function automatic logic [7:0] pick_write();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0, 1, 2: b[7:6] = WFN_PEN;
            3, 4:    b[7:6] = WFN_COLOUR;
            5:
            begin
                b[7:6] = WFN_CONFIG;
                b[4]   = 1'b0;
            end
            7:       b[7:6] = WFN_NONE;
            default: ;
        endcase
        return b;
    endfunction

    task automatic send_extra();
        if ($urandom_range(0, 3) == 0)
            send_event(CMD_DISPEN, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        else
            send_event(CMD_WRITE, 1'($urandom_range(0, 1)), pick_write());
    endtask

    // One scan line: hsync high, a run of cycle ticks, hsync low, then
    // register traffic and, half the time, an acknowledge when the interrupt is up.
    task automatic send_line();
        int unsigned ticks;
        int unsigned extras;
        ticks  = $urandom_range(0, 8);
        extras = $urandom_range(0, 2);
        send_event(CMD_HSYNC, 1'b1, 8'($urandom_range(0, 255)));
        repeat (ticks)
        begin
            if ($urandom_range(0, 5) == 0)
                send_extra();
            send_event(CMD_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        send_event(CMD_HSYNC, 1'b0, 8'($urandom_range(0, 255)));
        repeat (extras)
            send_extra();
        if (sb.irq_pending && $urandom_range(0, 1) == 0)
            send_event(CMD_ACK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // Stimulus
    initial
    begin
        int unsigned next_switch;
        int unsigned vs_lines;
        bit          vs_high;
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = '0;
        level       = 1'b0;
        data        = '0;
        idle_en     = 1'b1;
        events_done = 0;
        next_switch = 64;
        vs_lines    = 0;
        vs_high     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed corner cases
        send_event(CMD_ACK,    1'b0, 8'h00);
        send_event(CMD_HSYNC,  1'b1, 8'h00);
        send_event(CMD_TICK,   1'b0, 8'h00);
        send_event(CMD_TICK,   1'b0, 8'hff);
        send_event(CMD_HSYNC,  1'b1, 8'hff);   // hsync high again restarts the count
        send_event(CMD_TICK,   1'b1, 8'h00);
        send_event(CMD_TICK,   1'b0, 8'h00);
        send_event(CMD_HSYNC,  1'b0, 8'h00);   // ends the monitor hsync early
        send_event(CMD_WRITE,  1'b0, 8'h0f);
        send_event(CMD_WRITE,  1'b1, 8'h5f);
        send_event(CMD_WRITE,  1'b0, 8'h10);
        send_event(CMD_WRITE,  1'b0, 8'h40);
        send_event(CMD_WRITE,  1'b0, 8'h83);
        send_event(CMD_WRITE,  1'b0, 8'h9c);
        send_event(CMD_WRITE,  1'b1, 8'hff);   // function 11 does nothing
        send_event(3'd6,       1'b1, 8'hff);
        send_event(3'd7,       1'b0, 8'h00);
        send_event(CMD_DISPEN, 1'b0, 8'h00);
        send_event(CMD_DISPEN, 1'b1, 8'hff);
        send_event(CMD_VSYNC,  1'b1, 8'h00);
        send_event(CMD_VSYNC,  1'b1, 8'h00);   // same level is dropped
        send_event(CMD_TICK,   1'b1, 8'hff);   // tick outside hblank
        send_event(CMD_VSYNC,  1'b0, 8'h00);
        send_event(CMD_VSYNC,  1'b0, 8'hff);

        // random frames
        while (events_done < 650)
        begin
            if (events_done >= next_switch)
            begin
                idle_en     = $urandom_range(0, 3) != 0;
                next_switch = next_switch + 64;
            end
            if (events_done >= 560)
                idle_en = 1'b0;
            if ($urandom_range(0, 6) == 0)
                send_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
            else
            begin
                send_line();
                if (!vs_high && $urandom_range(0, 39) == 0)
                begin
                    send_event(CMD_VSYNC, 1'b1, 8'($urandom_range(0, 255)));
                    vs_high  = 1'b1;
                    vs_lines = $urandom_range(1, 10);
                end
                else if (vs_high)
                begin
                    if (vs_lines == 0)
                    begin
                        send_event(CMD_VSYNC, 1'b0, 8'($urandom_range(0, 255)));
                        vs_high = 1'b0;
                    end
                    else
                        vs_lines--;
                end
            end
        end
        in_valid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Check each result transfer, then decide the next ready level.
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                seen.irq_request    = irq_request;
                seen.hblank         = hblank;
                seen.vblank         = vblank;
                seen.border_active  = border_active;
                seen.monitor_hsync  = monitor_hsync;
                seen.monitor_vsync  = monitor_vsync;
                seen.screen_mode    = screen_mode;
                seen.rom_config     = rom_config;
                seen.palette_pen    = palette_pen;
                seen.palette_colour = palette_colour;
                seen.palette_write  = palette_write;
                seen.ack_data       = ack_data;
                sb.check_result(seen);
            end
            if (idle_en && stall_left == 0 && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vgaib_pkg.sv
rtl/core/video_gate_array_interrupt_blanking_top.sv
rtl/core/vgaib_checker.sv
dv/gate_status_sb_pkg.sv
dv/tb_video_gate_array_interrupt_blanking_top.sv
